// ----- hw/rtl/ostpc_pkg.sv -----
// Shared types and constants for the odd-only sieve twin prime counter.
// Holds the field widths, the count ceiling and the sequencer state type.
// No dependencies.
`default_nettype none

package ostpc_pkg;

	localparam int unsigned LIMIT_W = 17;
	localparam int unsigned PAIRS_W = 15;
	localparam logic [PAIRS_W-1:0] PAIRS_MAX = 15'h7fff;
	localparam int unsigned SMALL_LIMIT = 5;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_FILL  = 8'b0000_0010,
		ST_PRD   = 8'b0000_0100,
		ST_PTEST = 8'b0000_1000,
		ST_MARK  = 8'b0001_0000,
		ST_SCAN  = 8'b0010_0000,
		ST_DRAIN = 8'b0100_0000,
		ST_FIN   = 8'b1000_0000
	} state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/odd_sieve_twin_prime_counter_core.sv -----
// Phases: the flag memory is filled with E = (n-1)/2 entries, the marking loop makes M writes
// (about 1.4*E at the top of the range) for the odd candidates K up to sqrt(n), the flags are
// scanned and counted, and the result is posted. A limit below 5 goes straight to the result.
// Flow: one limit at a time; in_ready is high only in the idle state.
// Reset: arst_n clears the sequencer and the output valid; the flag memory keeps no reset.
// Depends on ostpc_pkg.
`default_nettype none

module odd_sieve_twin_prime_counter_core #(
	parameter int unsigned MAX_N = 65536
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [ostpc_pkg::LIMIT_W-1:0] limit,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [ostpc_pkg::PAIRS_W-1:0]      twin_pairs
);

	import ostpc_pkg::*;

	localparam int unsigned DEPTH = MAX_N / 2 + 1;
	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned JW = AW + 2;
	localparam int unsigned NW = $clog2(MAX_N + 1);
	localparam int unsigned CW = ((NW > LIMIT_W) ? NW : LIMIT_W) + 2;

	state_t state_q;

	logic [JW-1:0] entries_q;
	logic [JW-1:0] idx_q;
	logic [JW-1:0] k_q;
	logic [JW-1:0] j0_q;
	logic [JW-1:0] j_q;
	logic [PAIRS_W-1:0] count_q;
	logic rv_q;
	logic first_q;
	logic prev_q;
	logic rdata_q;

	logic mem_q [DEPTH];

	logic [CW-1:0] lim_ext;
	logic [CW-1:0] n_c;
	logic [JW-1:0] entries_w;
	logic [JW-1:0] p_w;
	logic [JW-1:0] jn_w;
	logic [JW-1:0] j0_next;
	logic [JW-1:0] last_idx;
	logic small_w;

	logic          we;
	logic [AW-1:0] wa;
	logic          wd;
	logic [AW-1:0] ra;

	assign lim_ext   = CW'(limit);
	assign n_c       = (lim_ext > CW'(MAX_N)) ? CW'(MAX_N) : lim_ext;
	assign small_w   = n_c < CW'(SMALL_LIMIT);
	assign entries_w = JW'((n_c - CW'(1)) >> 1);
	assign p_w       = JW'((k_q << 1) + JW'(3));
	assign jn_w      = j_q + p_w;
	assign j0_next   = j0_q + (p_w << 1) + JW'(2);
	assign last_idx  = entries_q - JW'(1);

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		we = 1'b0;
		wa = idx_q[AW-1:0];
		wd = 1'b1;
		ra = idx_q[AW-1:0];
		case (state_q)
			ST_FILL: begin
				we = 1'b1;
			end
			ST_MARK: begin
				we = 1'b1;
				wa = j_q[AW-1:0];
				wd = 1'b0;
			end
			ST_PRD: begin
				ra = k_q[AW-1:0];
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
		rdata_q <= mem_q[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
			rv_q      <= 1'b0;
		end else begin
			rv_q <= (state_q == ST_SCAN);
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= small_w ? ST_FIN : ST_FILL;
					end
				end
				ST_FILL: begin
					if (idx_q == last_idx) begin
						state_q <= ST_PRD;
					end
				end
				ST_PRD: begin
					state_q <= (j0_q < entries_q) ? ST_PTEST : ST_SCAN;
				end
				ST_PTEST: begin
					state_q <= rdata_q ? ST_MARK : ST_PRD;
				end
				ST_MARK: begin
					if (jn_w >= entries_q) begin
						state_q <= ST_PRD;
					end
				end
				ST_SCAN: begin
					if (idx_q == last_idx) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rv_q) begin
			if (!first_q && rdata_q && prev_q && count_q != PAIRS_MAX) begin
				count_q <= count_q + PAIRS_W'(1);
			end
			prev_q  <= rdata_q;
			first_q <= 1'b0;
		end
		case (state_q)
			ST_IDLE: begin
				entries_q <= entries_w;
				idx_q     <= '0;
				k_q       <= '0;
				j0_q      <= JW'(3);
				count_q   <= '0;
				first_q   <= 1'b1;
			end
			ST_FILL: begin
				idx_q <= (idx_q == last_idx) ? '0 : idx_q + JW'(1);
			end
			ST_PTEST: begin
				if (rdata_q) begin
					j_q <= j0_q;
				end else begin
					k_q  <= k_q + JW'(1);
					j0_q <= j0_next;
				end
			end
			ST_MARK: begin
				if (jn_w >= entries_q) begin
					k_q  <= k_q + JW'(1);
					j0_q <= j0_next;
				end else begin
					j_q <= jn_w;
				end
			end
			ST_SCAN: begin
				idx_q <= idx_q + JW'(1);
			end
			ST_FIN: begin
				if (!out_valid || out_ready) begin
					twin_pairs <= count_q;
				end
			end
			default: begin
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("block still ready after input transfer");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !we)
		else $error("flag write while idle");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> JW'(wa) < entries_q)
		else $error("flag write beyond active entries");

	a_result_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN && (!out_valid || out_ready) |=> out_valid
			&& twin_pairs == $past(count_q))
		else $error("result does not match final count");
`endif

endmodule

`default_nettype wire
